[hw/rtl/csn_pkg.sv]
// ----------------------------------------------------------------------------
// csn_pkg
// Shared constants for the color sensor nearest-color sequencer.
// ----------------------------------------------------------------------------
package csn_pkg;

    // Sizes
    localparam int NUM_REFS   = 6;
    localparam int TIME_BITS  = 25;
    localparam int LEVEL_W    = 18;
    localparam int REF_W      = 3 * LEVEL_W;
    localparam int NAME_W     = 8;
    localparam int NAMES_W    = NUM_REFS * NAME_W;
    localparam int REF_IDX_W  = (NUM_REFS > 1) ? $clog2(NUM_REFS) : 1;
    localparam int CFG_IDX_W  = $clog2(NUM_REFS + 1);
    localparam int CFG_DATA_W = (REF_W > NAMES_W) ? REF_W : NAMES_W;
    localparam int SQ_W       = 2 * LEVEL_W;
    localparam int DIST_W     = SQ_W + 2;

    // Period scaling
    localparam int PERIOD_DIV = 100;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

    // Reciprocal of the period scale, rounded up; the product shifted right by
    // DIV_SHIFT is the exact floor quotient for any TIME_BITS-wide dividend
    localparam int DIV_SHIFT   = TIME_BITS + $clog2(PERIOD_DIV);
    localparam int DIV_MAGIC_W = TIME_BITS + 1;
    localparam logic [DIV_MAGIC_W-1:0] DIV_MAGIC =
        DIV_MAGIC_W'(((64'd1 << DIV_SHIFT) + 64'(PERIOD_DIV - 1)) / 64'(PERIOD_DIV));

    // Best-match threshold: squared distance 1000000 (distance 1000)
    localparam logic [DIST_W-1:0] DIST_LIMIT = DIST_W'(1000000);

    // Event kinds
    localparam logic [1:0] FUNC_EDGE   = 2'd0;
    localparam logic [1:0] FUNC_TICK   = 2'd1;
    localparam logic [1:0] FUNC_TOGGLE = 2'd2;

    // Register index of the name codes
    localparam logic [CFG_IDX_W-1:0] CFG_REF_NAMES = CFG_IDX_W'(NUM_REFS);

    // Filter phases
    localparam logic [1:0] PH_RED   = 2'd0;
    localparam logic [1:0] PH_GREEN = 2'd1;
    localparam logic [1:0] PH_BLUE  = 2'd2;

endpackage

[hw/rtl/csn_div100.sv]
// ----------------------------------------------------------------------------
// csn_div100
// Divide by the period scale through a reciprocal multiply, result registered in
// the cycle after start, with the quotient saturated to the channel level width.
// ----------------------------------------------------------------------------
module csn_div100 (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [csn_pkg::TIME_BITS-1:0] dividend,
    output logic                          done,
    output logic [csn_pkg::LEVEL_W-1:0]   quotient
);
    import csn_pkg::*;

    localparam int PROD_W = TIME_BITS + DIV_MAGIC_W;
    localparam int Q_W    = PROD_W - DIV_SHIFT;

    logic              done_reg,  done_next;
    logic [PROD_W-1:0] prod_reg,  prod_next;
    logic [Q_W-1:0]    q_full;

    // Multiply by the rounded-up reciprocal on start
    always_comb begin
        done_next = start;
        prod_next = prod_reg;
        if (start) begin
            prod_next = PROD_W'(dividend) * PROD_W'(DIV_MAGIC);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
        end
        prod_reg <= prod_next;
    end

    // Upper product bits are the quotient; clamp to the level range
    assign q_full   = prod_reg[PROD_W-1:DIV_SHIFT];
    assign done     = done_reg;
    assign quotient = (q_full > Q_W'(LEVEL_MAX)) ? LEVEL_MAX : q_full[LEVEL_W-1:0];

endmodule

[hw/rtl/color_sensor_nearest_color_sequencer.sv]
// ----------------------------------------------------------------------------
// color_sensor_nearest_color_sequencer
// Measures sensor periods, steps the red/green/blue filter phase and picks the
// nearest reference color with one shared subtract/square/accumulate unit.
// ----------------------------------------------------------------------------
// Window tick: 6 refs x 3 channels pass through the 3 steps of the shared
//   square unit, then the output state; new beats wait until it is done.
// An edge beat after a prior edge waits in ST_DIV for the reciprocal divide.
//   Ready is low while a beat is in work or a stalled result blocks the output.
// Reset (aresetn low, synchronous): stopped, red phase, first pass, all
//   channels and reference registers zero, no result pending.
module color_sensor_nearest_color_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port
    input  logic                          cfg_we,
    input  logic [csn_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [csn_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Event stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [24:0] capture_time
    input  logic [1:0]                    s_tuser,   // [1:0] func
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [1:0] filter_select, [19:2] red_level, [37:20] green_level,
    // [55:38] blue_level, [58:56] color_index, [66:59] color_name
    output logic [71:0]                   m_tdata,
    output logic                          m_tlast    // frame_ready
);
    import csn_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIFF,
        ST_SQ,
        ST_ACC,
        ST_OUT
    } state_t;

    state_t                 state_reg,    state_next;
    logic                   running_reg,  running_next;
    logic [1:0]             phase_reg,    phase_next;
    logic                   first_reg,    first_next;
    logic                   seen_reg,     seen_next;
    logic [TIME_BITS-1:0]   last_reg,     last_next;
    logic [LEVEL_W-1:0]     period_reg,   period_next;
    logic [LEVEL_W-1:0]     level_reg [3];
    logic [LEVEL_W-1:0]     level_next [3];
    logic [REF_W-1:0]       ref_reg [NUM_REFS];
    logic [REF_W-1:0]       ref_next [NUM_REFS];
    logic [NAMES_W-1:0]     names_reg,    names_next;

    // Search unit
    logic [REF_IDX_W-1:0]   k_reg,        k_next;
    logic [1:0]             ch_reg,       ch_next;
    logic [LEVEL_W-1:0]     diff_reg,     diff_next;
    logic [SQ_W-1:0]        sq_reg,       sq_next;
    logic [DIST_W-1:0]      acc_reg,      acc_next;
    logic [DIST_W-1:0]      best_reg,     best_next;
    logic [REF_IDX_W-1:0]   pick_reg,     pick_next;
    logic [1:0]             sel_reg,      sel_next;
    logic                   ready_reg,    ready_next;

    // Output beat
    logic                   mvalid_reg,   mvalid_next;
    logic [71:0]            mdata_reg,    mdata_next;
    logic                   mlast_reg,    mlast_next;

    // Divider
    logic                   div_start;
    logic [TIME_BITS-1:0]   div_dividend;
    logic                   div_done;
    logic [LEVEL_W-1:0]     div_q;

    logic                   in_fire;
    logic [1:0]             in_func;
    logic [TIME_BITS-1:0]   in_time;
    logic [LEVEL_W-1:0]     ref_ch;
    logic [LEVEL_W-1:0]     lvl_ch;
    logic [DIST_W-1:0]      sum;
    logic [1:0]             slot;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign in_func  = s_tuser;
    assign in_time  = s_tdata[TIME_BITS-1:0];

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

    csn_div100 u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_q)
    );

    // Operand select for the shared unit: red, green, blue of reference k
    always_comb begin
        unique case (ch_reg)
            PH_RED: begin
                ref_ch = ref_reg[k_reg][2*LEVEL_W +: LEVEL_W];
                lvl_ch = level_reg[0];
            end
            PH_GREEN: begin
                ref_ch = ref_reg[k_reg][LEVEL_W +: LEVEL_W];
                lvl_ch = level_reg[1];
            end
            PH_BLUE: begin
                ref_ch = ref_reg[k_reg][0 +: LEVEL_W];
                lvl_ch = level_reg[2];
            end
            default: begin
                ref_ch = '0;
                lvl_ch = '0;
            end
        endcase
    end

    assign sum  = acc_reg + DIST_W'(sq_reg);
    assign slot = (phase_reg == PH_RED) ? PH_BLUE : (phase_reg - 2'd1);

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        running_next = running_reg;
        phase_next   = phase_reg;
        first_next   = first_reg;
        seen_next    = seen_reg;
        last_next    = last_reg;
        period_next  = period_reg;
        level_next   = level_reg;
        ref_next     = ref_reg;
        names_next   = names_reg;
        k_next       = k_reg;
        ch_next      = ch_reg;
        diff_next    = diff_reg;
        sq_next      = sq_reg;
        acc_next     = acc_reg;
        best_next    = best_reg;
        pick_next    = pick_reg;
        sel_next     = sel_reg;
        ready_next   = ready_reg;
        mvalid_next  = mvalid_reg;
        mdata_next   = mdata_reg;
        mlast_next   = mlast_reg;
        div_start    = 1'b0;
        div_dividend = in_time - last_reg;

        // Output beat taken
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        // Configuration writes
        if (cfg_we) begin
            for (int i = 0; i < NUM_REFS; i++) begin
                if (cfg_addr == CFG_IDX_W'(i)) begin
                    ref_next[i] = cfg_wdata[REF_W-1:0];
                end
            end
            if (cfg_addr == CFG_REF_NAMES) begin
                names_next = cfg_wdata[NAMES_W-1:0];
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (in_func == FUNC_TOGGLE) begin
                        running_next = !running_reg;
                    end else if (running_reg && in_func == FUNC_EDGE) begin
                        last_next = in_time;
                        seen_next = 1'b1;
                        if (seen_reg) begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end else if (running_reg && in_func == FUNC_TICK) begin
                        level_next[slot] = first_reg ? '0 : period_reg;
                        sel_next         = phase_reg;
                        ready_next       = (phase_reg == PH_RED) && !first_reg;
                        seen_next        = 1'b0;
                        period_next      = '0;
                        phase_next       = (phase_reg == PH_BLUE) ? PH_RED : phase_reg + 2'd1;
                        if (phase_reg == PH_BLUE) begin
                            first_next = 1'b0;
                        end
                        k_next     = '0;
                        ch_next    = PH_RED;
                        acc_next   = '0;
                        best_next  = DIST_LIMIT;
                        pick_next  = '0;
                        state_next = ST_DIFF;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    period_next = div_q;
                    state_next  = ST_IDLE;
                end
            end
            ST_DIFF: begin
                diff_next  = (ref_ch > lvl_ch) ? (ref_ch - lvl_ch) : (lvl_ch - ref_ch);
                state_next = ST_SQ;
            end
            ST_SQ: begin
                sq_next    = diff_reg * diff_reg;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                state_next = ST_DIFF;
                if (ch_reg == PH_BLUE) begin
                    // strict compare keeps the earlier reference on a tie
                    if (sum < best_reg) begin
                        best_next = sum;
                        pick_next = k_reg;
                    end
                    acc_next = '0;
                    ch_next  = PH_RED;
                    if (k_reg == REF_IDX_W'(NUM_REFS - 1)) begin
                        state_next = ST_OUT;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end else begin
                    acc_next = sum;
                    ch_next  = ch_reg + 2'd1;
                end
            end
            ST_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mlast_next  = ready_reg;
                    mdata_next  = {5'd0,
                                   names_reg[pick_reg*NAME_W +: NAME_W],
                                   pick_reg,
                                   level_reg[2], level_reg[1], level_reg[0],
                                   sel_reg};
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            running_reg <= 1'b0;
            phase_reg   <= PH_RED;
            first_reg   <= 1'b1;
            seen_reg    <= 1'b0;
            last_reg    <= '0;
            period_reg  <= '0;
            for (int i = 0; i < 3; i++) begin
                level_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_REFS; i++) begin
                ref_reg[i] <= '0;
            end
            names_reg   <= '0;
            mvalid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            running_reg <= running_next;
            phase_reg   <= phase_next;
            first_reg   <= first_next;
            seen_reg    <= seen_next;
            last_reg    <= last_next;
            period_reg  <= period_next;
            level_reg   <= level_next;
            ref_reg     <= ref_next;
            names_reg   <= names_next;
            mvalid_reg  <= mvalid_next;
        end
        k_reg     <= k_next;
        ch_reg    <= ch_next;
        diff_reg  <= diff_next;
        sq_reg    <= sq_next;
        acc_reg   <= acc_next;
        best_reg  <= best_next;
        pick_reg  <= pick_next;
        sel_reg   <= sel_next;
        ready_reg <= ready_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
    end

endmodule

[tb/tb_color_sensor_nearest_color_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_color_sensor_nearest_color_sequencer
// Drives edge, tick and toggle beats with random gaps and back-pressure. An
// in-bench model of the period measurement, filter sequencing and nearest
// reference search predicts every result beat, and the monitor checks each
// beat field by field. Three palette settings are loaded between quiet spells.
// ----------------------------------------------------------------------------
module tb_color_sensor_nearest_color_sequencer;
    import csn_pkg::*;

    localparam logic [1:0] FUNC_SPARE   = 2'd3;   // undefined kind, dropped
    localparam int         CYCLE_LIMIT  = 600000;
    localparam int         DRAIN_CYCLES = 80;     // covers the slowest beat
    localparam int         SET_SMALL    = 0;
    localparam int         SET_EXTREME  = 1;
    localparam int         SET_TIES     = 2;

    typedef struct packed {
        logic [1:0]           func;
        logic [TIME_BITS-1:0] stamp;
    } sensor_evt_t;

    typedef struct packed {
        logic [1:0]           filt;
        logic                 frame;
        logic [LEVEL_W-1:0]   red;
        logic [LEVEL_W-1:0]   green;
        logic [LEVEL_W-1:0]   blue;
        logic [REF_IDX_W-1:0] idx;
        logic [NAME_W-1:0]    name;
    } color_frame_t;

    // DUT ports; the inputs are at known values from time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [71:0]           m_tdata;
    logic                  m_tlast;

    color_sensor_nearest_color_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Model state, mirrors the block's reset
    logic [REF_W-1:0]     ref_tab [NUM_REFS] = '{default: '0};
    logic [NAMES_W-1:0]   name_tab   = '0;
    logic                 run_on     = 1'b0;
    logic [1:0]           ph         = PH_RED;
    logic                 warming    = 1'b1;
    logic                 have_edge  = 1'b0;
    logic [TIME_BITS-1:0] prev_edge  = '0;
    logic [LEVEL_W-1:0]   period_lvl = '0;
    logic [LEVEL_W-1:0]   levels [3] = '{default: '0};

    sensor_evt_t  events_pending[$];
    color_frame_t frames_due[$];
    sensor_evt_t  cur_evt;

    // Stimulus bookkeeping
    logic       gen_running = 1'b0;
    logic [1:0] gen_phase   = PH_RED;
    int         gen_target  = 0;
    int         useful_cnt  = 0;
    int         pushed_cnt  = 0;
    int         accepted_cnt = 0;
    int         err_cnt     = 0;
    int         cycle_cnt   = 0;
    int         src_idle    = 0;
    int         sink_idle   = 0;
    bit         calm        = 1'b0;
    logic       in_taken    = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Nearest reference by exact squared distance; ties keep the lower index
    function automatic logic [REF_IDX_W-1:0] nearest_ref();
        longint unsigned best, d2;
        longint dlt;
        logic [REF_IDX_W-1:0] pick;
        best = 64'd1000000;
        pick = '0;
        for (int k = 0; k < NUM_REFS; k++) begin
            d2 = 0;
            for (int c = 0; c < 3; c++) begin
                dlt = longint'(ref_tab[k][(2-c)*LEVEL_W +: LEVEL_W]) - longint'(levels[c]);
                d2 += longint'(dlt * dlt);
            end
            if (d2 < best) begin
                best = d2;
                pick = REF_IDX_W'(k);
            end
        end
        return pick;
    endfunction

    // Apply one accepted beat to the model; ticks queue an expected frame
    task automatic advance_sequencer(input sensor_evt_t ev);
        color_frame_t nf;
        logic [TIME_BITS-1:0] span;
        int unsigned quo;
        int slot;
        if (ev.func == FUNC_TOGGLE) begin
            run_on = !run_on;
            return;
        end
        if (!run_on || ev.func == FUNC_SPARE)
            return;
        if (ev.func == FUNC_EDGE) begin
            if (have_edge) begin
                span = ev.stamp - prev_edge;   // wraps at the timer width
                quo  = 32'(span) / 32'(PERIOD_DIV);
                period_lvl = (quo > 32'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(quo);
            end
            prev_edge = ev.stamp;
            have_edge = 1'b1;
            return;
        end
        // window tick: store into the channel read during the last window
        slot = (ph == PH_RED) ? 2 : int'(ph) - 1;
        levels[slot] = warming ? '0 : period_lvl;
        nf.filt  = ph;
        nf.frame = (ph == PH_RED) && !warming;
        nf.red   = levels[0];
        nf.green = levels[1];
        nf.blue  = levels[2];
        nf.idx   = nearest_ref();
        nf.name  = name_tab[NAME_W*nf.idx +: NAME_W];
        have_edge  = 1'b0;
        period_lvl = '0;
        ph = (ph == PH_BLUE) ? PH_RED : ph + 2'd1;
        if (warming && ph == PH_RED)
            warming = 1'b0;
        frames_due.push_back(nf);
    endtask

    // Queue one beat and track run state and phase for the generator
    task automatic push_event(input logic [1:0] f, input logic [TIME_BITS-1:0] t);
        sensor_evt_t ev;
        ev.func  = f;
        ev.stamp = t;
        if (f == FUNC_TOGGLE || (gen_running && (f == FUNC_EDGE || f == FUNC_TICK)))
            useful_cnt++;
        if (f == FUNC_TOGGLE)
            gen_running = !gen_running;
        else if (f == FUNC_TICK && gen_running)
            gen_phase = (gen_phase == PH_BLUE) ? PH_RED : gen_phase + 2'd1;
        events_pending.push_back(ev);
        pushed_cnt++;
    endtask

    // One measurement window: a few edges, mostly aimed at a palette entry
    task automatic add_window();
        int slot, pick, n_edges, v, base;
        logic [TIME_BITS-1:0] t;
        int unsigned span;
        if (!gen_running)
            push_event(FUNC_TOGGLE, TIME_BITS'($urandom));
        slot = (gen_phase == PH_RED) ? 2 : int'(gen_phase) - 1;
        if (slot == 0)
            gen_target = $urandom_range(0, NUM_REFS - 1);
        pick = $urandom_range(0, 9);
        n_edges = (pick == 9) ? $urandom_range(0, 1) : $urandom_range(2, 4);
        if (pick <= 5) begin
            base = int'(ref_tab[gen_target][(2-slot)*LEVEL_W +: LEVEL_W]);
            if ($urandom_range(0, 3) == 0)
                v = base + int'($urandom_range(0, 1600)) - 800;
            else
                v = base + int'($urandom_range(0, 50)) - 25;
        end else if (pick == 6) begin
            v = int'($urandom_range(0, int'(LEVEL_MAX)));
        end else begin
            v = int'($urandom_range(0, 500));
        end
        if (v < 0)
            v = 0;
        if (v > int'(LEVEL_MAX))
            v = int'(LEVEL_MAX);
        span = 32'(v) * 32'(PERIOD_DIV) + $urandom_range(0, PERIOD_DIV - 1);
        if (pick == 8)
            span = $urandom_range(26214400, (1 << TIME_BITS) - 1);   // saturates
        t = TIME_BITS'($urandom);
        for (int i = 0; i < n_edges; i++) begin
            push_event(FUNC_EDGE, t);
            if ($urandom_range(0, 9) == 0)
                push_event(FUNC_SPARE, TIME_BITS'($urandom));
            t = t + TIME_BITS'((i == n_edges - 2) ? span : $urandom);
        end
        push_event(FUNC_TICK, TIME_BITS'($urandom));
    endtask

    // Mostly well-formed windows, with stray toggles, edges and ticks
    task automatic add_traffic(input int n_items);
        int goal, pick;
        goal = useful_cnt + n_items;
        while (useful_cnt < goal) begin
            pick = $urandom_range(0, 19);
            case (pick)
                0: push_event(FUNC_TOGGLE, TIME_BITS'($urandom));
                1: push_event(FUNC_SPARE, TIME_BITS'($urandom));
                2: push_event(FUNC_EDGE, TIME_BITS'($urandom));
                3: push_event(FUNC_TICK, TIME_BITS'($urandom));
                default: add_window();
            endcase
        end
    endtask

    function automatic logic [REF_W-1:0] pack_rgb(input int unsigned top);
        return {LEVEL_W'($urandom_range(0, top)), LEVEL_W'($urandom_range(0, top)),
                LEVEL_W'($urandom_range(0, top))};
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == CFG_REF_NAMES)
            name_tab = val[NAMES_W-1:0];
        else
            ref_tab[idx] = val[REF_W-1:0];
    endtask

    task automatic load_setting(input int style);
        logic [REF_W-1:0]   pal [NUM_REFS];
        logic [NAMES_W-1:0] names;
        for (int k = 0; k < NUM_REFS; k++)
            pal[k] = pack_rgb((style == SET_EXTREME) ? 32'(LEVEL_MAX) : 4000);
        names = NAMES_W'({$urandom, $urandom});
        if (style == SET_EXTREME) begin
            pal[0] = '0;
            pal[1] = '1;
            names  = '1;
        end
        if (style == SET_TIES) begin
            pal[3] = pal[0];
            pal[5] = pal[2];
        end
        for (int k = 0; k < NUM_REFS; k++)
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'(pal[k]));
        write_reg(CFG_REF_NAMES, CFG_DATA_W'(names));
    endtask

    // Sender holds off until every beat is in and every frame is out
    task automatic settle();
        while (accepted_cnt != pushed_cnt || frames_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic check_field(input string fname, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            err_cnt++;
        end
    endtask

    // Input acceptance feeds the model
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            advance_sequencer(cur_evt);
            accepted_cnt++;
        end
        in_taken <= aresetn && s_tvalid && s_tready;
    end

    // Event driver with random gap bursts
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (src_idle > 0) begin
                src_idle--;
                s_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                src_idle = $urandom_range(0, 13);
                s_tvalid <= 1'b0;
            end else if (events_pending.size() != 0) begin
                cur_evt = events_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= 32'(cur_evt.stamp);
                s_tuser  <= cur_evt.func;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result back-pressure in bursts
    always @(negedge aclk) begin
        if (aresetn) begin
            if (sink_idle > 0)
                sink_idle--;
            else if (!calm && $urandom_range(0, 7) == 0)
                sink_idle = $urandom_range(1, 14);
            m_tready <= (sink_idle == 0);
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        color_frame_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (frames_due.size() == 0) begin
                $error("result beat with no frame expected");
                err_cnt++;
            end else begin
                want = frames_due.pop_front();
                check_field("filter_select", want.filt,  m_tdata[1:0]);
                check_field("frame_ready",   want.frame, m_tlast);
                check_field("red_level",     want.red,   m_tdata[19:2]);
                check_field("green_level",   want.green, m_tdata[37:20]);
                check_field("blue_level",    want.blue,  m_tdata[55:38]);
                check_field("color_index",   want.idx,   m_tdata[58:56]);
                check_field("color_name",    want.name,  m_tdata[66:59]);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        load_setting(SET_SMALL);

        // stopped: edges, ticks and the spare kind are dropped
        push_event(FUNC_TICK, '0);
        push_event(FUNC_EDGE, 25'h1ABCDE);
        push_event(FUNC_SPARE, '1);
        push_event(FUNC_TOGGLE, '0);
        // first pass stores zeros even after a saturating period
        push_event(FUNC_EDGE, '0);
        push_event(FUNC_EDGE, 25'h1FFFFFF);
        push_event(FUNC_TICK, '0);
        push_event(FUNC_EDGE, 25'd100);
        push_event(FUNC_TICK, '0);
        push_event(FUNC_TICK, '1);
        // timer wrap between edges, frame ready at red phase
        push_event(FUNC_EDGE, 25'h1FFFFF0);
        push_event(FUNC_EDGE, 25'h0000100);
        push_event(FUNC_TICK, '0);
        // largest unsaturated quotient
        push_event(FUNC_EDGE, '0);
        push_event(FUNC_EDGE, 25'd26214399);
        push_event(FUNC_TICK, '0);
        // one past the level range, spare kind while running
        push_event(FUNC_EDGE, 25'd5);
        push_event(FUNC_EDGE, 25'd26214405);
        push_event(FUNC_SPARE, '0);
        push_event(FUNC_TICK, '0);
        // period just below one unit
        push_event(FUNC_EDGE, 25'd7);
        push_event(FUNC_EDGE, 25'd106);
        push_event(FUNC_TICK, '0);
        // stop, ignored beats, restart
        push_event(FUNC_TOGGLE, '1);
        push_event(FUNC_TICK, '0);
        push_event(FUNC_EDGE, '1);
        push_event(FUNC_TOGGLE, '0);

        add_traffic(340);
        settle();
        load_setting(SET_EXTREME);
        add_traffic(360);
        settle();
        load_setting(SET_TIES);
        calm = 1'b1;
        add_traffic(360);
        settle();

        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
hw/rtl/csn_pkg.sv
hw/rtl/csn_div100.sv
hw/rtl/color_sensor_nearest_color_sequencer.sv
tb/tb_color_sensor_nearest_color_sequencer.sv
